[hdl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// No dependencies; used by text_console_writer_core.
package tcw_pkg;

  // Fixed field widths of the stream payloads.
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ROWF_W  = 5;
  localparam int COLF_W  = 7;
  localparam int CELL_W  = CHAR_W + COLOR_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Character and color codes.
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR  = 8'h0A;
  localparam logic [CHAR_W-1:0]  SPACE_CHAR    = 8'h20;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 8'h07;

  // Request kinds carried on tuser.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_MOVE  = 4'b1000
  } state_t;

endpackage

[hdl/text_console_writer_core.sv]
// Text console writer: cell store, cursor tracking and scroll sequencer.
// Depends on tcw_pkg for types and constants.

// A write request of a printable byte is stored when it is accepted and, unless it
// scrolls, its result is registered at the same edge; a read request goes through the
// registered read of the cell memory and then ST_READ, which registers its result. A
// write that moves past the last row scrolls the screen: one memory pass copies every
// row up and blanks the last row, and no request is taken until it is done. After
// reset the same memory, with one write port and one registered read port, is swept to
// spaces in color 7 before the first request is accepted. The color register can be
// written at any time and is used for new characters and blanked rows.
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write: text color.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: character[7:0], read_row[12:8], read_col[19:13], zero fill.
  input  logic [23:0] in_tdata,
  // tuser: action (0 write, 1 read).
  input  logic        in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: cursor_row[4:0], cursor_col[11:5], scrolled[12],
  // cell_char[20:13], cell_color[28:21], zero fill.
  output logic [31:0] out_tdata
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END    = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] FIRST_SRC   = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);

  // Request fields.
  logic [tcw_pkg::CHAR_W-1:0] in_char;
  logic [tcw_pkg::ROWF_W-1:0] in_row;
  logic [tcw_pkg::COLF_W-1:0] in_col;
  logic                       in_acc;
  logic                       rd_hit;
  logic [ADDR_W-1:0]          rd_addr;

  // State.
  tcw_pkg::state_t             state_r, state_nxt;
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [ADDR_W-1:0]           base_r, base_nxt;
  logic [ADDR_W-1:0]           dst_r, dst_nxt;
  logic [ADDR_W-1:0]           src_r, src_nxt;
  logic                        rd_ok_r, rd_ok_nxt;
  logic [tcw_pkg::COLOR_W-1:0] color_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [31:0]                 out_data_r, out_data_nxt;
  logic [ADDR_W-1:0]           cur_addr;

  // Memory port.
  logic [tcw_pkg::CELL_W-1:0]  mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0]  mem_q_r;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_wa;
  logic [ADDR_W-1:0]           mem_ra;
  logic [tcw_pkg::CELL_W-1:0]  mem_wd;

  assign in_char = in_tdata[7:0];
  assign in_row  = in_tdata[12:8];
  assign in_col  = in_tdata[19:13];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == tcw_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cur_addr = base_r + ADDR_W'(col_r);

  // Linear address of a read request; out-of-screen reads use address zero.
  always_comb begin
    rd_hit  = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLUMNS));
    rd_addr = rd_hit ? ADDR_W'(32'(in_row) * 32'(COLUMNS) + 32'(in_col)) : '0;
  end

  // Sequencer, cursor update and result assembly.
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    dst_nxt       = dst_r;
    src_nxt       = src_r;
    rd_ok_nxt     = rd_ok_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_wa        = dst_r;
    mem_wd        = {tcw_pkg::DEFAULT_COLOR, tcw_pkg::SPACE_CHAR};
    mem_ra        = '0;

    case (state_r)
      // Sweep the store to spaces in the default color after reset.
      tcw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (dst_r == LAST_ADDR) begin
          dst_nxt   = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          dst_nxt = dst_r + 1'b1;
        end
      end

      // Take a request; printable bytes are stored at the cursor right away.
      tcw_pkg::ST_IDLE: begin
        mem_ra = (in_tuser == tcw_pkg::ACT_READ) ? rd_addr : FIRST_SRC;
        mem_wa = cur_addr;
        mem_wd = {color_r, in_char};
        if (in_acc) begin
          if (in_tuser == tcw_pkg::ACT_READ) begin
            rd_ok_nxt = rd_hit;
            state_nxt = tcw_pkg::ST_READ;
          end else begin
            mem_we = (in_char != tcw_pkg::NEWLINE_CHAR);
            if ((in_char == tcw_pkg::NEWLINE_CHAR) || (col_r == LAST_COL)) begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                // Scroll: the read of the first source cell is already issued.
                src_nxt   = FIRST_SRC + 1'b1;
                dst_nxt   = '0;
                state_nxt = tcw_pkg::ST_MOVE;
              end else begin
                row_nxt       = row_r + 1'b1;
                base_nxt      = base_r + ROW_STEP;
                out_valid_nxt = 1'b1;
                out_data_nxt  = {19'd0, 1'b0, tcw_pkg::COLF_W'(0),
                                 tcw_pkg::ROWF_W'(row_r + 1'b1)};
              end
            end else begin
              col_nxt       = col_r + 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = {19'd0, 1'b0, tcw_pkg::COLF_W'(col_r + 1'b1),
                               tcw_pkg::ROWF_W'(row_r)};
            end
          end
        end
      end

      // Registered cell data is back; return it or zero when off screen.
      tcw_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {3'd0,
                         rd_ok_r ? mem_q_r : {tcw_pkg::CELL_W{1'b0}},
                         1'b0, tcw_pkg::COLF_W'(col_r), tcw_pkg::ROWF_W'(row_r)};
        state_nxt     = tcw_pkg::ST_IDLE;
      end

      // Copy each cell one row up, then blank the last row in the current color.
      tcw_pkg::ST_MOVE: begin
        mem_we = 1'b1;
        mem_ra = src_r;
        mem_wd = (dst_r < COPY_END) ? mem_q_r : {color_r, tcw_pkg::SPACE_CHAR};
        if (src_r != LAST_ADDR) begin
          src_nxt = src_r + 1'b1;
        end
        if (dst_r == LAST_ADDR) begin
          dst_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {19'd0, 1'b1, tcw_pkg::COLF_W'(col_r), tcw_pkg::ROWF_W'(row_r)};
          state_nxt     = tcw_pkg::ST_IDLE;
        end else begin
          dst_nxt = dst_r + 1'b1;
        end
      end

      default: begin
        state_nxt = tcw_pkg::ST_CLEAR;
        dst_nxt   = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      dst_r       <= '0;
      src_r       <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      color_r     <= tcw_pkg::DEFAULT_COLOR;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      dst_r       <= dst_nxt;
      src_r       <= src_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        color_r <= cfg_data;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Cell memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  // The row base always tracks the cursor row.
  a_base_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    base_r == ADDR_W'(32'(row_r) * 32'(COLUMNS)))
    else $error("row base does not match cursor row");

  // The cursor stays on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= LAST_ROW) && (col_r <= LAST_COL))
    else $error("cursor left the screen");

  // A read request is answered after the registered memory read and the ST_READ state.
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == tcw_pkg::ACT_READ)) |=> ##1 out_valid_r)
    else $error("read result missing");

  // A result only appears while the sequencer is done or on a direct write.
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tcw_pkg::ST_MOVE) || (state_r == tcw_pkg::ST_CLEAR)) |-> !out_valid_r)
    else $error("result shown while the memory pass runs");

endmodule
